FILE: hdl/spf_pkg.sv
`timescale 1ns / 1ps

package spf_pkg;

    // Largest value the table covers; the table holds one entry per value 0..MAX_VALUE.
    localparam int MAX_VALUE   = 4095;
    localparam int TBL_DEPTH   = MAX_VALUE + 1;
    localparam int VAL_W       = 12;
    localparam int EXP_W       = 4;
    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = 3;
    localparam int DIV_CNT_W   = $clog2(VAL_W);

    localparam logic REQ_BUILD  = 1'b0;
    localparam logic REQ_FACTOR = 1'b1;

    typedef enum logic [2:0] {
        ST_FACTOR   = 3'd0,
        ST_NONE     = 3'd1,
        ST_RANGE    = 3'd2,
        ST_NOTBUILT = 3'd3,
        ST_DONE     = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_OUT_RD,
        S_OUT_CHK,
        S_IN_RD,
        S_IN_CHK,
        S_Q_RD,
        S_Q_LOOK,
        S_DIV_WAIT,
        S_EMIT,
        S_STATUS
    } t_state;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [VAL_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quot;
        logic [VAL_W-1:0] rem;
    } t_div_rsp;

endpackage

FILE: hdl/spf_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module spf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spf_pkg::t_div_req i_req,
    output spf_pkg::t_div_rsp o_rsp
);

    logic [spf_pkg::VAL_W-1:0]     r_quo;
    logic [spf_pkg::VAL_W-1:0]     r_rem;
    logic [spf_pkg::VAL_W-1:0]     r_dvs;
    logic [spf_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [spf_pkg::VAL_W:0]   trial;
    logic [spf_pkg::VAL_W:0]   diff;
    logic                      ge;
    logic [spf_pkg::VAL_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[spf_pkg::VAL_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
        n_rem = ge ? diff[spf_pkg::VAL_W-1:0] : trial[spf_pkg::VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == spf_pkg::DIV_CNT_W'(spf_pkg::VAL_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[spf_pkg::VAL_W-2:0], ge};
            r_rem <= n_rem;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

FILE: hdl/spf_sieve_factorizer_unit.sv
`timescale 1ns / 1ps
// Build: clears entries 0..L of the built limit L, then reads each candidate from 2 up to L;
// each prime found stamps its unstamped multiples up to L, and then the result is posted.
// Factor: per distinct prime, a table lookup, divisions by it until one leaves a remainder,
// then one emit; status-only answers skip the table. One request at a time, taken when idle.
// Synchronous active-low reset clears control, the built flag and built limit, and sets the
// limit register to 4095; the table is not swept, as a build clears entries 0..L first.

module spf_sieve_factorizer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel
    input  logic                          i_req_valid,
    output logic                          o_req_stall,
    input  logic                          i_req_type,
    input  logic [spf_pkg::VAL_W-1:0]     i_value,
    // Result channel
    output logic                          o_res_valid,
    input  logic                          i_res_stall,
    output logic [spf_pkg::VAL_W-1:0]     o_prime,
    output logic [spf_pkg::EXP_W-1:0]     o_exponent,
    output logic [2:0]                    o_status,
    output logic                          o_last,
    // Configuration channel (table_limit)
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [spf_pkg::VAL_W-1:0]     i_cfg_data
);

    // The smallest-prime-factor table. All accesses are strictly sequential: a read is
    // issued in one state and its data is consumed (and possibly written back) in the
    // next, so no read whose data is used overlaps a write to the same entry.
    logic [spf_pkg::VAL_W-1:0] r_table [spf_pkg::TBL_DEPTH];
    logic [spf_pkg::VAL_W-1:0] r_rd_data;
    logic                      mem_we;
    logic [spf_pkg::VAL_W-1:0] mem_waddr;
    logic [spf_pkg::VAL_W-1:0] mem_wdata;
    logic [spf_pkg::VAL_W-1:0] mem_raddr;

    spf_pkg::t_state           r_state, n_state;
    logic [spf_pkg::VAL_W-1:0] r_table_limit;
    logic [spf_pkg::VAL_W-1:0] r_built_limit, n_built_limit;
    logic                      r_ready, n_ready;

    // Sieve counters: r_i is the candidate prime, r_j walks its multiples.
    logic [spf_pkg::VAL_W-1:0] r_i, n_i;
    logic [spf_pkg::VAL_W-1:0] r_j, n_j;

    // Factoring state: remaining value, current prime, exponent, result count.
    logic [spf_pkg::VAL_W-1:0] r_n, n_n;
    logic [spf_pkg::VAL_W-1:0] r_p, n_p;
    logic [spf_pkg::EXP_W-1:0] r_e, n_e;
    logic [spf_pkg::CNT_W-1:0] r_cnt, n_cnt;
    spf_pkg::t_status          r_status, n_status;

    // Output register; a new result is loaded whenever the previous one is gone or
    // is being taken in this cycle.
    logic                      r_out_valid;
    logic [spf_pkg::VAL_W-1:0] r_out_prime;
    logic [spf_pkg::EXP_W-1:0] r_out_exp;
    spf_pkg::t_status          r_out_status;
    logic                      r_out_last;
    logic                      out_free;
    logic                      out_load;
    logic [spf_pkg::VAL_W-1:0] ld_prime;
    logic [spf_pkg::EXP_W-1:0] ld_exp;
    spf_pkg::t_status          ld_status;
    logic                      ld_last;

    spf_pkg::t_div_req         div_req;
    spf_pkg::t_div_rsp         div_rsp;

    logic                      req_take;
    logic [spf_pkg::VAL_W:0]   i_next;
    logic [spf_pkg::VAL_W:0]   j_next;
    logic                      i_done;
    logic                      emit_last;
    logic [spf_pkg::VAL_W-1:0] p_sel;

    spf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_req_stall = (r_state != spf_pkg::S_IDLE);
    assign req_take    = i_req_valid && !o_req_stall;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_res_stall;

    assign i_next = {1'b0, r_i} + 1'b1;
    assign j_next = {1'b0, r_j} + {1'b0, r_i};
    assign i_done = (i_next > {1'b0, r_built_limit});
    // A table entry below two is treated as "the remaining value is prime".
    assign p_sel  = (r_rd_data < spf_pkg::VAL_W'(2)) ? r_n : r_rd_data;
    assign emit_last = (r_n == spf_pkg::VAL_W'(1)) ||
                       (r_cnt == spf_pkg::CNT_W'(spf_pkg::MAX_RESULTS - 1));

    always_comb begin
        n_state       = r_state;
        n_built_limit = r_built_limit;
        n_ready       = r_ready;
        n_i           = r_i;
        n_j           = r_j;
        n_n           = r_n;
        n_p           = r_p;
        n_e           = r_e;
        n_cnt         = r_cnt;
        n_status      = r_status;
        mem_we        = 1'b0;
        mem_waddr     = r_j;
        mem_wdata     = '0;
        mem_raddr     = r_j;
        div_req       = '0;
        out_load      = 1'b0;
        ld_prime      = '0;
        ld_exp        = '0;
        ld_status     = r_status;
        ld_last       = 1'b1;

        unique case (r_state)
            spf_pkg::S_IDLE: begin
                if (req_take) begin
                    if (i_req_type == spf_pkg::REQ_BUILD) begin
                        // A limit above the top of the table builds up to the top only.
                        n_built_limit = (r_table_limit > spf_pkg::VAL_W'(spf_pkg::MAX_VALUE)) ?
                                        spf_pkg::VAL_W'(spf_pkg::MAX_VALUE) : r_table_limit;
                        n_ready       = 1'b1;
                        n_j           = '0;
                        n_status      = spf_pkg::ST_DONE;
                        n_state       = spf_pkg::S_CLEAR;
                    end else if (!r_ready) begin
                        n_status = spf_pkg::ST_NOTBUILT;
                        n_state  = spf_pkg::S_STATUS;
                    end else if (i_value <= spf_pkg::VAL_W'(1)) begin
                        n_status = spf_pkg::ST_NONE;
                        n_state  = spf_pkg::S_STATUS;
                    end else if (i_value > r_built_limit) begin
                        n_status = spf_pkg::ST_RANGE;
                        n_state  = spf_pkg::S_STATUS;
                    end else begin
                        n_n     = i_value;
                        n_cnt   = '0;
                        n_state = spf_pkg::S_Q_RD;
                    end
                end
            end
            spf_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = '0;
                if (r_j == r_built_limit) begin
                    if (r_built_limit < spf_pkg::VAL_W'(2)) begin
                        n_state = spf_pkg::S_STATUS;
                    end else begin
                        n_i     = spf_pkg::VAL_W'(2);
                        n_state = spf_pkg::S_OUT_RD;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            spf_pkg::S_OUT_RD: begin
                mem_raddr = r_i;
                n_state   = spf_pkg::S_OUT_CHK;
            end
            spf_pkg::S_OUT_CHK: begin
                if (r_rd_data == '0) begin
                    n_j     = r_i;
                    n_state = spf_pkg::S_IN_RD;
                end else if (i_done) begin
                    n_state = spf_pkg::S_STATUS;
                end else begin
                    n_i     = i_next[spf_pkg::VAL_W-1:0];
                    n_state = spf_pkg::S_OUT_RD;
                end
            end
            spf_pkg::S_IN_RD: begin
                mem_raddr = r_j;
                n_state   = spf_pkg::S_IN_CHK;
            end
            spf_pkg::S_IN_CHK: begin
                if (r_rd_data == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_j;
                    mem_wdata = r_i;
                end
                if (j_next <= {1'b0, r_built_limit}) begin
                    n_j     = j_next[spf_pkg::VAL_W-1:0];
                    n_state = spf_pkg::S_IN_RD;
                end else if (i_done) begin
                    n_state = spf_pkg::S_STATUS;
                end else begin
                    n_i     = i_next[spf_pkg::VAL_W-1:0];
                    n_state = spf_pkg::S_OUT_RD;
                end
            end
            spf_pkg::S_Q_RD: begin
                mem_raddr = r_n;
                n_state   = spf_pkg::S_Q_LOOK;
            end
            spf_pkg::S_Q_LOOK: begin
                n_p              = p_sel;
                n_e              = '0;
                div_req.start    = 1'b1;
                div_req.dividend = r_n;
                div_req.divisor  = p_sel;
                n_state          = spf_pkg::S_DIV_WAIT;
            end
            spf_pkg::S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem == '0) begin
                        // The prime divides again: keep the quotient and try once more.
                        n_n              = div_rsp.quot;
                        n_e              = r_e + 1'b1;
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quot;
                        div_req.divisor  = r_p;
                    end else begin
                        n_state = spf_pkg::S_EMIT;
                    end
                end
            end
            spf_pkg::S_EMIT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    ld_prime  = r_p;
                    ld_exp    = r_e;
                    ld_status = spf_pkg::ST_FACTOR;
                    ld_last   = emit_last;
                    n_cnt     = r_cnt + 1'b1;
                    n_state   = emit_last ? spf_pkg::S_IDLE : spf_pkg::S_Q_RD;
                end
            end
            spf_pkg::S_STATUS: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    ld_status = r_status;
                    ld_last   = 1'b1;
                    n_state   = spf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spf_pkg::S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= spf_pkg::S_IDLE;
            r_table_limit <= spf_pkg::VAL_W'(spf_pkg::MAX_VALUE);
            r_built_limit <= '0;
            r_ready       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_built_limit <= n_built_limit;
            r_ready       <= n_ready;
            r_out_valid   <= out_load || (r_out_valid && i_res_stall);
            if (i_cfg_valid && o_cfg_ready) begin
                r_table_limit <= i_cfg_data;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_n      <= n_n;
        r_p      <= n_p;
        r_e      <= n_e;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        if (out_load) begin
            r_out_prime  <= ld_prime;
            r_out_exp    <= ld_exp;
            r_out_status <= ld_status;
            r_out_last   <= ld_last;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_table[mem_raddr];
    end

    assign o_res_valid = r_out_valid;
    assign o_prime     = r_out_prime;
    assign o_exponent  = r_out_exp;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

`ifndef ASSERT_OFF
    // The table is only written by the clearing sweep and the sieve.
    a_write_only_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == spf_pkg::S_CLEAR || r_state == spf_pkg::S_IN_CHK))
        else $error("table written outside a build");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || !i_res_stall))
        else $error("result register overwritten");

    // The divider works bit by bit; no answer may come right after a start.
    a_div_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> !div_rsp.done)
        else $error("divider answered too early");

    // A lookup is only made for a remaining value inside the built table.
    a_lookup_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spf_pkg::S_Q_RD) |->
            (r_n >= spf_pkg::VAL_W'(2) && r_n <= r_built_limit))
        else $error("lookup outside the built table");

    // A request never yields more results than the cap.
    a_result_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spf_pkg::S_EMIT) |->
            (r_cnt < spf_pkg::CNT_W'(spf_pkg::MAX_RESULTS)))
        else $error("result count over the cap");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // One result transaction as the block should deliver it.
    typedef struct {
        logic [spf_pkg::VAL_W-1:0] prime;
        logic [spf_pkg::EXP_W-1:0] exponent;
        spf_pkg::t_status          status;
        logic                      last;
    } t_factor_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_req_valid = 1'b0;
    logic                      o_req_stall;
    logic                      i_req_type = spf_pkg::REQ_BUILD;
    logic [spf_pkg::VAL_W-1:0] i_value = '0;
    logic                      o_res_valid;
    logic                      i_res_stall = 1'b0;
    logic [spf_pkg::VAL_W-1:0] o_prime;
    logic [spf_pkg::EXP_W-1:0] o_exponent;
    logic [2:0]                o_status;
    logic                      o_last;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [spf_pkg::VAL_W-1:0] i_cfg_data = '0;

    // Shadow of the block's state: the sieve table, the limit register, the
    // limit the table was last built for, and whether any build has happened.
    logic [spf_pkg::VAL_W-1:0] spf_table [0:spf_pkg::MAX_VALUE];
    logic [spf_pkg::VAL_W-1:0] cfg_limit;
    logic [spf_pkg::VAL_W-1:0] built_limit;
    logic                      table_built;

    // Factor results still owed by the block, oldest first.
    t_factor_result            pending_factors[$];
    int                        error_count = 0;

    // Percent chance per cycle that the request side holds back, and that the
    // result side stalls.
    int                        req_gap_pct = 0;
    int                        res_stall_pct = 0;

    spf_sieve_factorizer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req_type  (i_req_type),
        .i_value     (i_value),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_prime     (o_prime),
        .o_exponent  (o_exponent),
        .o_status    (o_status),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // The receiver decides its stall at each falling edge, so the value is
    // settled well before the rising edge where the transaction is judged.
    always @(negedge i_clk) begin
        i_res_stall <= ($urandom_range(99) < res_stall_pct);
    end

    task automatic push_result(input int prime, input int expo, input spf_pkg::t_status st,
                               input logic last);
        t_factor_result r;
        r.prime    = prime[spf_pkg::VAL_W-1:0];
        r.exponent = expo[spf_pkg::EXP_W-1:0];
        r.status   = st;
        r.last     = last;
        pending_factors.push_back(r);
    endtask

    // Works out what one accepted request produces and updates the shadow state.
    task automatic predict_request(input logic rtype, input logic [spf_pkg::VAL_W-1:0] val);
        int lim;
        int i;
        int j;
        int rem;
        int p;
        int expo;
        int count;
        if (rtype == spf_pkg::REQ_BUILD) begin
            // A fresh sieve: every unstamped multiple of a new prime gets that prime.
            lim = cfg_limit;
            if (lim > spf_pkg::MAX_VALUE) lim = spf_pkg::MAX_VALUE;
            for (i = 0; i <= spf_pkg::MAX_VALUE; i++) spf_table[i] = '0;
            for (i = 2; i <= lim; i++) begin
                if (spf_table[i] == 0) begin
                    for (j = i; j <= lim; j += i) begin
                        if (spf_table[j] == 0) spf_table[j] = i[spf_pkg::VAL_W-1:0];
                    end
                end
            end
            built_limit = lim[spf_pkg::VAL_W-1:0];
            table_built = 1'b1;
            push_result(0, 0, spf_pkg::ST_DONE, 1'b1);
        end else if (!table_built) begin
            push_result(0, 0, spf_pkg::ST_NOTBUILT, 1'b1);
        end else if (val <= 1) begin
            push_result(0, 0, spf_pkg::ST_NONE, 1'b1);
        end else if (val > built_limit) begin
            push_result(0, 0, spf_pkg::ST_RANGE, 1'b1);
        end else begin
            // Peel off the smallest prime factor until nothing is left. The
            // primes come out in ascending order; the last one carries the flag.
            rem   = val;
            count = 0;
            while (rem > 1 && count < spf_pkg::MAX_RESULTS) begin
                p = spf_table[rem];
                if (p < 2) p = rem;
                expo = 0;
                while (rem % p == 0) begin
                    rem = rem / p;
                    expo++;
                end
                count++;
                push_result(p, expo, spf_pkg::ST_FACTOR,
                            (rem <= 1) || (count == spf_pkg::MAX_RESULTS));
            end
        end
    endtask

    // Sends one request transaction. Idle cycles are decided before valid
    // rises, so valid never reacts to the stall.
    task automatic send_request(input logic rtype, input logic [spf_pkg::VAL_W-1:0] val);
        while ($urandom_range(99) < req_gap_pct) begin
            @(negedge i_clk);
            i_req_valid = 1'b0;
        end
        @(negedge i_clk);
        i_req_valid = 1'b1;
        i_req_type  = rtype;
        i_value     = val;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        predict_request(rtype, val);
    endtask

    // Drops valid and waits until every owed result has come back, plus a
    // short pause so the block is surely back in its idle state.
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_req_valid = 1'b0;
        while (pending_factors.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // The limit register is only written while the block is idle.
    task automatic write_table_limit(input logic [spf_pkg::VAL_W-1:0] lim);
        wait_for_drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = lim;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_limit = lim;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic void report_mismatch(input string field, input int want,
                                            input int got);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        error_count++;
    endfunction

    // Every accepted result transaction is matched against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        t_factor_result want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (pending_factors.size() == 0) begin
                $display("%0t ns: result with nothing expected, prime %0d exponent %0d",
                         $time, o_prime, o_exponent);
                $display("%0t ns: unexpected result status %0d last %0d",
                         $time, o_status, o_last);
                error_count++;
            end else begin
                want = pending_factors.pop_front();
                if (o_prime !== want.prime) report_mismatch("prime", want.prime, o_prime);
                if (o_exponent !== want.exponent)
                    report_mismatch("exponent", want.exponent, o_exponent);
                if (o_status !== want.status) report_mismatch("status", want.status, o_status);
                if (o_last !== want.last) report_mismatch("last", want.last, o_last);
            end
        end
    end

    // Queries before any build must all be refused as not built.
    task automatic test_before_build();
        send_request(spf_pkg::REQ_FACTOR, 12'd0);
        send_request(spf_pkg::REQ_FACTOR, 12'd1);
        send_request(spf_pkg::REQ_FACTOR, 12'd4095);
    endtask

    // Build with the limit left at its reset value, then factor values that
    // reach the corners: the top value, a pure power of two with the largest
    // exponent, a product of five distinct primes, a large prime, and the two
    // values that have no factors.
    task automatic test_default_limit();
        send_request(spf_pkg::REQ_BUILD, 12'd0);
        send_request(spf_pkg::REQ_FACTOR, 12'd4095);
        send_request(spf_pkg::REQ_FACTOR, 12'd2048);
        send_request(spf_pkg::REQ_FACTOR, 12'd2310);
        send_request(spf_pkg::REQ_FACTOR, 12'd4093);
        send_request(spf_pkg::REQ_FACTOR, 12'd0);
        send_request(spf_pkg::REQ_FACTOR, 12'd1);
    endtask

    // Limits of zero and one leave an empty table: only 0 and 1 answer, and
    // everything else is out of range. A limit of two holds a single prime.
    task automatic test_small_limits();
        for (int lim = 0; lim <= 2; lim++) begin
            write_table_limit(lim[spf_pkg::VAL_W-1:0]);
            send_request(spf_pkg::REQ_BUILD, 12'hFFF);
            send_request(spf_pkg::REQ_FACTOR, 12'd1);
            send_request(spf_pkg::REQ_FACTOR, 12'd2);
            send_request(spf_pkg::REQ_FACTOR, 12'd3);
        end
    endtask

    // An explicit write of the largest limit.
    task automatic test_full_limit();
        write_table_limit(12'd4095);
        send_request(spf_pkg::REQ_BUILD, 12'd0);
        send_request(spf_pkg::REQ_FACTOR, 12'd4094);
        send_request(spf_pkg::REQ_FACTOR, 12'd3);
    endtask

    // One idling setting: a few table sizes, each built and then queried with
    // mostly in-range values, some out of range, the edges of the table, and
    // the occasional rebuild when the table is small enough to be cheap.
    task automatic run_random_phase(input int gap_pct, input int stall_pct);
        logic [spf_pkg::VAL_W-1:0] lim;
        int                        pick;
        req_gap_pct   = gap_pct;
        res_stall_pct = stall_pct;
        repeat (4) begin
            if ($urandom_range(9) == 0)
                lim = spf_pkg::VAL_W'($urandom_range(3500, spf_pkg::MAX_VALUE));
            else
                lim = spf_pkg::VAL_W'($urandom_range(2, 400));
            write_table_limit(lim);
            send_request(spf_pkg::REQ_BUILD, spf_pkg::VAL_W'($urandom()));
            repeat (18) begin
                pick = $urandom_range(99);
                if (pick < 8 && lim <= 1000)
                    send_request(spf_pkg::REQ_BUILD, spf_pkg::VAL_W'($urandom()));
                else if (pick < 65)
                    send_request(spf_pkg::REQ_FACTOR, spf_pkg::VAL_W'($urandom_range(0, lim)));
                else if (pick < 80)
                    send_request(spf_pkg::REQ_FACTOR, spf_pkg::VAL_W'($urandom()));
                else if (pick < 90)
                    send_request(spf_pkg::REQ_FACTOR,
                                 lim + spf_pkg::VAL_W'($urandom_range(0, 1)));
                else
                    send_request(spf_pkg::REQ_FACTOR, spf_pkg::VAL_W'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(20, 59);
        run_random_phase(59, 20);
        run_random_phase(0, 0);
    endtask

    initial begin
        // Shadow state after reset: no table, reset limit register.
        for (int i = 0; i <= spf_pkg::MAX_VALUE; i++) spf_table[i] = '0;
        cfg_limit     = 12'd4095;
        built_limit   = '0;
        table_built   = 1'b0;
        req_gap_pct   = 20;
        res_stall_pct = 59;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_before_build();
        test_default_limit();
        test_small_limits();
        test_full_limit();
        test_random_traffic();

        wait_for_drain();
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // A full-size build sweeps and sieves the whole table; the whole run stays far under
    // this bound even with many builds and heavy stalling.
    initial begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
